/* sv/sitrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sitrt_pkg;

  // quotient bits resolved per cycle by the shared divide unit
  localparam int DIV_STEP = 8;

  // digit symbol table: sixteen byte slots over two 64-bit registers
  localparam int SYM_SLOTS = 16;
  localparam int SYM_IDX_W = 4;
  localparam int TAB_W     = 128;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] SYM_MIN  = 8'd32;
  localparam logic [7:0] SYM_MAX  = 8'd122;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_FETCH,
    S_SIGN,
    S_EMIT
  } state_t;

  function automatic logic [7:0] symbol_at(input logic [TAB_W-1:0] tab,
                                           input logic [SYM_IDX_W-1:0] idx);
    return tab[{idx, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

/* sv/sitrt_table_check.sv */
`timescale 1ns / 1ps
`default_nettype none

module sitrt_table_check
  import sitrt_pkg::*;
#(
  parameter int MAX_RADIX = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [4:0]       base_length,
  input  wire logic [TAB_W-1:0] symbols,
  output logic                  table_ok
);

  logic [7:0]           sym [SYM_SLOTS];
  logic [SYM_SLOTS-1:0] used;
  logic                 bad;

  always_comb begin
    for (int i = 0; i < SYM_SLOTS; i++) begin
      sym[i]  = symbols[i*8 +: 8];
      used[i] = 5'(i) < base_length;
    end
  end

  // range, sign characters and pairwise duplicates over the symbols in use
  always_comb begin
    bad = (base_length < 5'd2) || (base_length > 5'(MAX_RADIX));
    for (int i = 0; i < SYM_SLOTS; i++) begin
      if (used[i] && (sym[i] == CH_PLUS || sym[i] == CH_MINUS ||
                      sym[i] < SYM_MIN || sym[i] > SYM_MAX)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < SYM_SLOTS; j++) begin
        if (used[j] && sym[i] == sym[j]) begin
          bad = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_ok <= 1'b0;
    end else begin
      table_ok <= !bad;
    end
  end

endmodule

`default_nettype wire

/* sv/sitrt_divider.sv */
`timescale 1ns / 1ps
`default_nettype none

module sitrt_divider
  import sitrt_pkg::*;
#(
  parameter int MAG_W = 32,
  parameter int REM_W = 4,
  parameter int RAD_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] dividend,
  input  wire logic [RAD_W-1:0] radix,
  output logic                  done,
  output logic [MAG_W-1:0]      quot,
  output logic [REM_W-1:0]      rem
);

  localparam int CYC   = MAG_W / DIV_STEP;
  localparam int CYC_W = (CYC > 1) ? $clog2(CYC) : 1;
  localparam int R_W   = REM_W + 1;

  logic             busy;
  logic [CYC_W-1:0] cnt;
  logic [MAG_W-1:0] q_step;
  logic [REM_W-1:0] r_step;
  logic [R_W-1:0]   trial;

  // restoring division, DIV_STEP quotient bits per cycle, quotient shifts in
  always_comb begin
    q_step = quot;
    r_step = rem;
    trial  = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial  = {r_step, q_step[MAG_W-1]};
      q_step = {q_step[MAG_W-2:0], 1'b0};
      if (trial >= R_W'(radix)) begin
        r_step    = REM_W'(trial - R_W'(radix));
        q_step[0] = 1'b1;
      end else begin
        r_step = trial[REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CYC_W'(CYC - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= q_step;
      rem  <= r_step;
    end
  end

endmodule

`default_nettype wire

/* sv/sitrt_digit_stack.sv */
`timescale 1ns / 1ps
`default_nettype none

module sitrt_digit_stack #(
  parameter int DEPTH = 32,
  parameter int DIG_W = 4
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DIG_W-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DIG_W-1:0]              rd_data
);

  logic [DIG_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/signed_integer_to_radix_text.sv */
// signed integer to radix text
// a request on the item channel (item_valid / item_ready, payload number)
// carries one signed number; the text channel (text_valid / text_ready,
// payload symbol, last) returns its characters one per request, most
// significant digit first, a leading '-' for negative numbers, last set on
// the final character. an invalid digit table gives no characters at all.
// the apb port holds base_length (0x00), symbols_low (0x08) and
// symbols_high (0x10); write them only while no item is in flight.
// timing: a check state, then each digit takes a full pass through the
// shared divide unit (8 quotient bits per cycle), then a fetch state; the
// characters then leave back to back unless the receiver stalls. item_ready
// is high only while the sequencer is idle. the last character sits in the
// output register while the next item is already taken. a stalled receiver
// holds the emit loop, nothing is lost. reset clears the configuration and
// control registers, which leaves the table invalid.
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_to_radix_text
  import sitrt_pkg::*;
#(
  parameter int MAX_RADIX   = 16,
  parameter int NUMBER_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [4:0]                    paddr,
  input  wire logic [63:0]                   pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready,
  // item channel
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire logic signed [NUMBER_BITS-1:0] number,
  // text channel
  output logic                               text_valid,
  input  wire logic                          text_ready,
  output logic [7:0]                         symbol,
  output logic                               last
);

  // divide unit works on a magnitude padded to whole DIV_STEP chunks
  localparam int DIV_CYC = (NUMBER_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int MAG_W   = DIV_CYC * DIV_STEP;
  localparam int REM_W   = $clog2(MAX_RADIX);
  localparam int RAD_W   = $clog2(MAX_RADIX + 1);
  localparam int CNT_W   = $clog2(NUMBER_BITS + 1);
  localparam int IDX_W   = $clog2(NUMBER_BITS);

  // configuration registers
  logic [4:0]  base_length;
  logic [63:0] symbols_low;
  logic [63:0] symbols_high;
  logic [TAB_W-1:0] symbols;
  logic        table_ok;

  // sequencer
  state_t                 state;
  state_t                 state_next;
  logic [NUMBER_BITS-1:0] mag;
  logic                   neg;
  logic [CNT_W-1:0]       nd;
  logic [CNT_W-1:0]       nd_next;
  logic [CNT_W-1:0]       nd_dec;
  logic                   slot_free;
  logic                   out_load;
  logic [7:0]             out_sym;
  logic                   out_last;

  // divide unit and digit stack
  logic             div_start;
  logic [MAG_W-1:0] div_dividend;
  logic             div_done;
  logic [MAG_W-1:0] div_quot;
  logic [REM_W-1:0] div_rem;
  logic             stk_wr;
  logic             stk_rd;
  logic [REM_W-1:0] stk_rdata;

  logic                   wr_hit;
  logic [NUMBER_BITS-1:0] num_u;

  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite && pready;
  assign symbols = {symbols_high, symbols_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (wr_hit) begin
      unique case (paddr[4:3])
        REG_BASE_LENGTH:  base_length  <= pwdata[4:0];
        REG_SYMBOLS_LOW:  symbols_low  <= pwdata;
        REG_SYMBOLS_HIGH: symbols_high <= pwdata;
        default: ;  // no register there
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_BASE_LENGTH:  prdata = {59'd0, base_length};
      REG_SYMBOLS_LOW:  prdata = symbols_low;
      REG_SYMBOLS_HIGH: prdata = symbols_high;
      default:          prdata = '0;
    endcase
  end

  // table validity, registered in the cycle after the configuration changes
  sitrt_table_check #(
    .MAX_RADIX (MAX_RADIX)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .base_length (base_length),
    .symbols     (symbols),
    .table_ok    (table_ok)
  );

  // first pass divides the captured magnitude, later passes the last quotient
  assign div_dividend = (state == S_CHECK) ? MAG_W'(mag) : div_quot;

  sitrt_divider #(
    .MAG_W (MAG_W),
    .REM_W (REM_W),
    .RAD_W (RAD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (RAD_W'(base_length)),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // digits land least significant first and are read back in reverse
  assign nd_dec = nd - CNT_W'(1);

  sitrt_digit_stack #(
    .DEPTH (NUMBER_BITS),
    .DIG_W (REM_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr),
    .wr_addr (nd[IDX_W-1:0]),
    .wr_data (div_rem),
    .rd_en   (stk_rd),
    .rd_addr (nd_dec[IDX_W-1:0]),
    .rd_data (stk_rdata)
  );

  // magnitude as unsigned, so the most negative value needs no special path
  assign num_u = number;

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      neg <= num_u[NUMBER_BITS-1];
      mag <= num_u[NUMBER_BITS-1] ? (~num_u + 1'b1) : num_u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nd    <= '0;
    end else begin
      state <= state_next;
      nd    <= nd_next;
    end
  end

  // output register may take a new character when empty or being drained
  assign slot_free = !text_valid || text_ready;

  always_comb begin
    state_next = state;
    nd_next    = nd;
    item_ready = 1'b0;
    div_start  = 1'b0;
    stk_wr     = 1'b0;
    stk_rd     = 1'b0;
    out_load   = 1'b0;
    out_sym    = '0;
    out_last   = 1'b0;
    unique case (state)
      S_IDLE: begin
        // no request is taken while in reset
        item_ready = !rst;
        if (item_valid && item_ready) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // invalid table: drop the item silently
        nd_next = '0;
        if (table_ok) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          stk_wr  = 1'b1;
          nd_next = nd + 1'b1;
          if (div_quot == '0) begin
            state_next = S_FETCH;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_FETCH: begin
        // prefetch the most significant digit
        stk_rd     = 1'b1;
        nd_next    = nd_dec;
        state_next = neg ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_sym    = CH_MINUS;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_sym  = symbol_at(symbols, SYM_IDX_W'(stk_rdata));
          out_last = (nd == '0);
          if (nd == '0) begin
            state_next = S_IDLE;
          end else begin
            stk_rd  = 1'b1;
            nd_next = nd_dec;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (out_load) begin
      text_valid <= 1'b1;
    end else if (text_ready) begin
      text_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      symbol <= out_sym;
      last   <= out_last;
    end
  end

  // a digit is never written past the end of the stack
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |-> (nd < CNT_W'(NUMBER_BITS)))
    else $error("digit stack overflow");

  // divide results only arrive while the sequencer waits for them
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  // the sign never closes a text, a valid table holds no '-'
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (text_valid && symbol == CH_MINUS) |-> !last)
    else $error("minus sign flagged as last character");

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import sitrt_pkg::*;

  localparam int MAX_RADIX    = 16;
  localparam int NUMBER_BITS  = 32;
  localparam int RANDOM_ITEMS = 300;
  // hold-off sized for the worst request, a sign plus 32 binary digits, plus margin
  localparam int HOLDOFF      = 250;
  // no register behind this index, writes to it must change nothing
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;
  logic item_valid;
  logic item_ready;
  logic signed [NUMBER_BITS-1:0] number;
  logic text_valid;
  logic text_ready;
  logic [7:0] symbol;
  logic last;

  // shadow copy of the configuration, updated at each register write
  logic [4:0] radix_reg;
  logic [TAB_W-1:0] table_reg;

  // characters still owed by the block, oldest first
  text_char_t pending_chars[$];
  text_char_t want;

  int error_count;
  bit tx_idling;
  bit rx_idling;
  int stall_left;
  int stall_pick;

  signed_integer_to_radix_text #(
    .MAX_RADIX(MAX_RADIX),
    .NUMBER_BITS(NUMBER_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .number(number),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .symbol(symbol),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #(32_000_000);
    $display("tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // table is usable only with radix 2..16, printable symbols, no signs, no repeats
  function automatic bit table_ok();
    logic [7:0] s;
    if (radix_reg < 2 || radix_reg > MAX_RADIX) return 1'b0;
    for (int i = 0; i < radix_reg; i++) begin
      s = table_reg[i*8 +: 8];
      if (s == CH_PLUS || s == CH_MINUS || s < SYM_MIN || s > SYM_MAX) return 1'b0;
      for (int j = i + 1; j < radix_reg; j++)
        if (table_reg[j*8 +: 8] == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the text of one number, sign first, then digits from the top
  function automatic void spell_number(input logic [NUMBER_BITS-1:0] value);
    logic [NUMBER_BITS-1:0] mag;
    logic [NUMBER_BITS-1:0] radix;
    logic [3:0] digit [NUMBER_BITS];
    int nd;
    if (!table_ok()) return;
    radix = NUMBER_BITS'(radix_reg);
    mag = value;
    nd = 0;
    // unsigned magnitude, so the most negative value needs no special path
    if (value[NUMBER_BITS-1]) mag = ~value + 1'b1;
    do begin
      digit[nd] = 4'(mag % radix);
      nd++;
      mag = mag / radix;
    end while (mag != 0);
    if (value[NUMBER_BITS-1]) pending_chars.push_back('{symbol: CH_MINUS, last: 1'b0});
    for (int k = nd - 1; k >= 0; k--)
      pending_chars.push_back('{symbol: table_reg[{digit[k], 3'b000} +: 8], last: (k == 0)});
  endfunction

  // ---------------------------------------------------------------------
  // text channel: receiver stalls and checking
  // ---------------------------------------------------------------------

  // always ready unless rx_idling; then mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (rst) begin
      text_ready <= 1'b0;
      stall_left = 0;
    end else if (!rx_idling) begin
      text_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      text_ready <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 65) begin
        text_ready <= 1'b1;
      end else if (stall_pick < 96) begin
        stall_left = $urandom_range(0, 2);
        text_ready <= 1'b0;
      end else begin
        stall_left = $urandom_range(10, 30);
        text_ready <= 1'b0;
      end
    end
  end

  // every accepted character against the oldest one owed
  always @(posedge clk) begin
    if (!rst && text_valid === 1'b1 && text_ready) begin
      if (pending_chars.size() == 0) begin
        error_count++;
        $display("%0t: unexpected character, expected none, got symbol=%h last=%b",
                 $time, symbol, last);
      end else begin
        want = pending_chars.pop_front();
        if (symbol !== want.symbol) begin
          error_count++;
          $display("%0t: symbol mismatch, expected %h, got %h", $time, want.symbol, symbol);
        end
        if (last !== want.last) begin
          error_count++;
          $display("%0t: last mismatch, expected %b, got %b", $time, want.last, last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // setup cycle then access cycle, the register takes the value on the access edge
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    item_valid <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BASE_LENGTH:  radix_reg = value[4:0];
      REG_SYMBOLS_LOW:  table_reg[63:0] = value;
      REG_SYMBOLS_HIGH: table_reg[127:64] = value;
      default: ;
    endcase
  endtask

  // radix goes out with junk in the unused upper bits
  task automatic load_table(input logic [4:0] radix, input logic [TAB_W-1:0] tab);
    logic [63:0] value;
    value = {$urandom, $urandom};
    value[4:0] = radix;
    write_reg(REG_BASE_LENGTH, value);
    write_reg(REG_SYMBOLS_LOW, tab[63:0]);
    write_reg(REG_SYMBOLS_HIGH, tab[127:64]);
  endtask

  function automatic int sender_gap();
    int pick;
    if (!tx_idling) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request on the item channel; valid stays up after acceptance so a
  // following request with no gap goes out back to back
  task automatic send_number(input logic [NUMBER_BITS-1:0] value);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    number <= value;
    do @(posedge clk); while (!item_ready);
    spell_number(value);
  endtask

  // drop valid and wait until all owed characters are back
  task automatic wait_text_done();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  // an item with a bad table leaves nothing owed but may still be in flight
  task automatic settle();
    wait_text_done();
    repeat (HOLDOFF) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // distinct legal symbols in the slots in use, any byte in the rest
  function automatic logic [TAB_W-1:0] random_table(input int n);
    logic [TAB_W-1:0] tab;
    logic [7:0] s;
    bit clash;
    for (int i = 0; i < SYM_SLOTS; i++) tab[i*8 +: 8] = 8'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      do begin
        s = 8'($urandom_range(SYM_MIN, SYM_MAX));
        clash = (s == CH_PLUS) || (s == CH_MINUS);
        for (int j = 0; j < i; j++)
          if (tab[j*8 +: 8] == s) clash = 1'b1;
      end while (clash);
      tab[i*8 +: 8] = s;
    end
    return tab;
  endfunction

  // full range, small values around the radix, extremes, radix powers and shifted values of any length
  function automatic logic [NUMBER_BITS-1:0] pick_number(input int radix);
    logic [NUMBER_BITS-1:0] v;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4: v = $urandom_range(0, 2 * radix);
      5: v = 0 - $urandom_range(1, 2 * radix);
      6: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '0;
          default: v = '1;
        endcase
      end
      7: begin
        v = 1;
        k = $urandom_range(1, 31);
        repeat (k) if (v <= 32'h7FFF_FFFF / radix) v = v * radix;
        v = v + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = 0 - v;
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = 0 - v;
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // registers clear to an empty table, so nothing comes out
  task automatic test_reset_state();
    send_number(32'd0);
    send_number(32'hFFFF_FFFF);
    settle();
  endtask

  // radix two: longest texts, 32 digits plus sign for the most negative value
  task automatic test_binary();
    // "01" with signs and out-of-range bytes in the unused slots
    load_table(5'd2, {64'h0000_0000_0000_0000, 64'h2B2D_00FF_7B1F_3130});
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'h5555_5555);
    settle();
  endtask

  // full sixteen-symbol table using both ends of the printable range
  task automatic test_hex();
    load_table(5'd16, {64'h7A64_6362_6139_3837, 64'h3635_3433_3231_3020});
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'hAAAA_AAAA);
    send_number(32'd15);
    send_number(32'hFFFF_FFF0);
    settle();
  endtask

  // decimal, junk signs in unused slots, a write to an empty index
  task automatic test_decimal();
    load_table(5'd10, {64'h2D2B_FFFF_0000_3938, 64'h3736_3534_3332_3130});
    write_reg(REG_UNUSED, {$urandom, $urandom});
    send_number(32'd0);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    settle();
  endtask

  // each way a table can be refused, one request apiece
  task automatic test_bad_tables();
    logic [4:0] radixes [9] = '{5'd0, 5'd1, 5'd17, 5'd31, 5'd10, 5'd10, 5'd10, 5'd16,
                                5'd10};
    logic [63:0] lows [9] = '{
      64'h3736_3534_3332_3130,   // radix zero
      64'h3736_3534_3332_3130,   // radix one
      64'h3635_3433_3231_3020,   // radix above the maximum
      64'h3635_3433_3231_3020,   // largest radix code
      64'h3736_3534_2B32_3130,   // plus sign in use
      64'h3736_3534_3332_3130,   // minus sign in use (high word)
      64'h3736_3534_3332_311F,   // symbol below the printable range
      64'h3635_3433_3231_3020,   // symbol above the range (high word)
      64'h3736_3534_3332_3130    // repeated symbol (high word)
    };
    logic [63:0] highs [9] = '{
      64'h0000_0000_0000_3938,
      64'h0000_0000_0000_3938,
      64'h7A64_6362_6139_3837,
      64'h7A64_6362_6139_3837,
      64'h0000_0000_0000_3938,
      64'h2D2B_FFFF_0000_2D38,
      64'h0000_0000_0000_3938,
      64'h7B64_6362_6139_3837,
      64'h2D2B_FFFF_0000_3038
    };
    for (int i = 0; i < 9; i++) begin
      load_table(radixes[i], {highs[i], lows[i]});
      send_number((i % 2) ? 32'h8000_0000 : 32'd12345);
      settle();
    end
  endtask

  // phases of random numbers, each under its own table; some tables broken
  task automatic test_random_traffic();
    int valid_items;
    int phase;
    int count;
    int pause_at;
    int radix;
    int slot;
    logic [4:0] radix_code;
    logic [TAB_W-1:0] tab;
    bit usable;
    valid_items = 0;
    phase = 0;
    while (valid_items < RANDOM_ITEMS) begin
      tx_idling = ($urandom_range(0, 3) != 0);
      rx_idling = ($urandom_range(0, 3) != 0);
      if (phase == 0) radix = 2;
      else if (phase == 1) radix = MAX_RADIX;
      else radix = $urandom_range(2, MAX_RADIX);
      tab = random_table(radix);
      radix_code = 5'(radix);
      // now and then break the table one way or another
      if (phase >= 2 && $urandom_range(0, 4) == 0) begin
        slot = $urandom_range(0, radix - 1);
        case ($urandom_range(0, 3))
          0: radix_code = 5'($urandom_range(0, 1));
          1: radix_code = 5'($urandom_range(MAX_RADIX + 1, 31));
          2: tab[slot*8 +: 8] = ($urandom_range(0, 1)) ? CH_PLUS : CH_MINUS;
          default: tab[slot*8 +: 8] = tab[((slot + 1) % radix)*8 +: 8];
        endcase
      end
      load_table(radix_code, tab);
      usable = table_ok();
      count = usable ? $urandom_range(20, 40) : 4;
      // sender holds off until the text is all back, always in the first phase
      pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ? $urandom_range(1, count - 1) : -1;
      for (int i = 0; i < count; i++) begin
        if (i == pause_at) wait_text_done();
        send_number(pick_number(radix));
      end
      if (usable) valid_items += count;
      settle();
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------

  initial begin
    error_count = 0;
    radix_reg = '0;
    table_reg = '0;
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    number = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_binary();
    test_hex();
    test_decimal();
    test_bad_tables();
    test_random_traffic();
    settle();

    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
